// ----- hdl/czn_pkg.sv -----
// Package for the column z-score normalizer.
// Holds the command/response payload types, codes, sizes and sequencer states.
// No dependencies.
`default_nettype none
package czn_pkg;

	localparam int MaxRows  = 256;
	localparam int MaxCols  = 16;
	localparam int FracBits = 16;

	localparam int SampleW = 32;
	localparam int RadW    = 64;
	localparam int RootW   = 32;

	typedef enum logic [1:0] {
		FUNC_STORE = 2'd0,
		FUNC_NORM  = 2'd1,
		FUNC_READ  = 2'd2,
		FUNC_CLEAR = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		STAT_OK      = 3'd0,
		STAT_FULL    = 3'd1,
		STAT_EMPTY   = 3'd2,
		STAT_ZERODEV = 3'd3,
		STAT_RANGE   = 3'd4
	} status_t;

	typedef struct packed {
		func_t              func;
		logic signed [31:0] sample_value;
		logic [7:0]         row_index;
		logic [3:0]         col_index;
	} cmd_t;

	typedef struct packed {
		logic signed [31:0] result_value;
		status_t            status;
		logic [8:0]         rows_held;
	} rsp_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_RD_WAIT,
		ST_SUM_RD,
		ST_SUM_ACC,
		ST_MEAN_DIV,
		ST_SQ_RD,
		ST_SQ_D,
		ST_SQ_MUL,
		ST_SQ_ACC,
		ST_VAR_DIV,
		ST_SQRT,
		ST_ZERO_WR,
		ST_N_RD,
		ST_N_D,
		ST_N_DIV,
		ST_N_WR,
		ST_COL_NEXT,
		ST_DONE
	} state_t;

endpackage
`default_nettype wire

// ----- hdl/czn_divider.sv -----
// Restoring divider, one quotient bit per cycle.
// Shared by the mean, variance and z-score divisions. Depends on nothing.
`default_nettype none
module czn_divider #(
	parameter int DivW = 80,
	parameter int DsrW = 32
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            go,
	input  wire logic [DivW-1:0] dividend,
	input  wire logic [DsrW-1:0] divisor,
	output logic                 done,
	output logic [DivW-1:0]      quotient,
	output logic [DsrW-1:0]      remainder
);
	localparam int CntW = $clog2(DivW + 1);

	logic [DivW-1:0] quo_q;
	logic [DsrW-1:0] rem_q, dsr_q;
	logic [CntW-1:0] cnt_q;
	logic            done_q;
	logic [DsrW:0]   trial;
	logic            fits;

	assign trial = {rem_q, quo_q[DivW-1]};
	assign fits  = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				cnt_q <= CntW'(DivW);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CntW'(1)) done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (cnt_q != '0) begin
			if (fits) begin
				rem_q <= DsrW'(trial - {1'b0, dsr_q});
			end else begin
				rem_q <= trial[DsrW-1:0];
			end
			quo_q <= {quo_q[DivW-2:0], fits};
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule
`default_nettype wire

// ----- hdl/czn_isqrt.sv -----
// Integer square root, two radicand bits per cycle.
// Depends on czn_pkg for the radicand and root widths.
`default_nettype none
module czn_isqrt (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  go,
	input  wire logic [czn_pkg::RadW-1:0] radicand,
	output logic                       done,
	output logic [czn_pkg::RootW-1:0]  root
);
	import czn_pkg::*;

	localparam int CntW = $clog2(RootW + 1);

	logic [RadW-1:0]  rad_q;
	logic [RootW+1:0] rem_q;
	logic [RootW-1:0] root_q;
	logic [CntW-1:0]  cnt_q;
	logic             done_q;
	logic [RootW+3:0] cur;
	logic [RootW+3:0] trial;
	logic             fits;

	assign cur   = {rem_q, rad_q[RadW-1 -: 2]};
	assign trial = {2'b00, root_q, 2'b01};
	assign fits  = cur >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				cnt_q <= CntW'(RootW);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CntW'(1)) done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (cnt_q != '0) begin
			rad_q <= {rad_q[RadW-3:0], 2'b00};
			if (fits) begin
				rem_q  <= (RootW+2)'(cur - trial);
				root_q <= {root_q[RootW-2:0], 1'b1};
			end else begin
				rem_q  <= cur[RootW+1:0];
				root_q <= {root_q[RootW-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule
`default_nettype wire

// ----- hdl/column_zscore_normalizer_unit.sv -----
// Top level of the column z-score normalizer: sample store, sequencer, datapath.
// Depends on czn_pkg, czn_divider and czn_isqrt.
//
// Use: drive cmd and raise start; the item is taken at a clock edge with start
// high and busy low. Exactly one response follows, on rsp for one cycle with
// rsp_valid high; it cannot be held off. cfg_we writes num_cols and empties the
// set; write it only while idle.
// Store, clear, failed reads and an empty normalize answer in the cycle after
// acceptance with busy low, so a new item may be taken every cycle. A good read
// holds busy in ST_RD_WAIT (registered memory read) and answers as busy falls.
// Normalize holds busy while, per column, it sums the rows, divides for the mean,
// sums the squared deviations, divides for the variance, takes the root and
// divides each row for its z-score (or writes zero when the deviation is zero);
// it repeats this for each further column and answers in the cycle busy falls.
// The bit-serial divider is 64 + bits of MAX_ROWS+1 (73 by default) bits wide.
// Reset empties the set and sets num_cols to 1; stored words are not cleared.
`default_nettype none
module column_zscore_normalizer_unit #(
	parameter int MAX_ROWS  = czn_pkg::MaxRows,
	parameter int MAX_COLS  = czn_pkg::MaxCols,
	parameter int FRAC_BITS = czn_pkg::FracBits
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output logic               busy,
	input  wire czn_pkg::cmd_t cmd,
	output logic               rsp_valid,
	output czn_pkg::rsp_t      rsp,
	input  wire logic          cfg_we,
	input  wire logic [4:0]    cfg_wdata
);
	import czn_pkg::*;

	localparam int Depth = MAX_ROWS * MAX_COLS;
	localparam int AddrW = $clog2(Depth);
	localparam int RiW   = $clog2(MAX_ROWS);
	localparam int NW    = $clog2(MAX_ROWS + 1);
	localparam int CiW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int NcW   = $clog2(MAX_COLS + 1);
	localparam int SumW  = SampleW + RiW + 1;
	localparam int SsW   = 2 * SampleW + NW;
	localparam int ZnW   = SampleW + 1 + FRAC_BITS;
	localparam int DivW  = (SsW > ZnW) ? SsW : ZnW;
	localparam int CmpW  = 16;

	state_t state_q, state_d;

	logic [SampleW-1:0] mem [Depth];
	logic [SampleW-1:0] rdata_q;
	logic               mem_we;
	logic [AddrW-1:0]   waddr, raddr;
	logic [SampleW-1:0] wdata;

	logic [4:0]     num_cols_q;
	logic [NW-1:0]  row_count_q;
	logic [CiW-1:0] col_ptr_q;
	logic [NcW-1:0] ncols;
	logic [RiW-1:0] r_q;
	logic [CiW-1:0] c_q;
	logic           row_last, col_last;

	logic signed [SumW-1:0] sum_q;
	logic [SumW-1:0]        sum_mag;
	logic signed [31:0]     mean_q;
	logic [32:0]            mag_q;
	logic                   dneg_q;
	logic signed [32:0]     dval;
	logic [65:0]            prod;
	logic [63:0]            sq_q;
	logic [SsW-1:0]         sumsq_q;
	logic [RadW-1:0]        var_q;
	logic [RootW-1:0]       dev_q;
	logic                   zdev_q;

	logic              unit_go_q;
	logic [DivW-1:0]   div_dividend, div_quo;
	logic [31:0]       div_divisor, div_rem, mean_mag;
	logic              div_done, sqrt_done;
	logic [RootW-1:0]  sqrt_root;
	logic [31:0]       zval;

	logic   accept;
	logic   rd_bad;
	logic   rsp_valid_q;
	logic signed [31:0] res_q;
	status_t status_q;

	assign accept = start && (state_q == ST_IDLE);
	assign busy   = (state_q != ST_IDLE);

	always_comb begin
		if (num_cols_q == 5'd0) begin
			ncols = NcW'(1);
		end else if (CmpW'(num_cols_q) > CmpW'(MAX_COLS)) begin
			ncols = NcW'(MAX_COLS);
		end else begin
			ncols = NcW'(num_cols_q);
		end
	end

	assign rd_bad   = (CmpW'(cmd.row_index) >= CmpW'(row_count_q)) ||
	                  (CmpW'(cmd.col_index) >= CmpW'(ncols));
	assign row_last = (CmpW'(r_q) == CmpW'(row_count_q) - CmpW'(1));
	assign col_last = (CmpW'(c_q) == CmpW'(ncols) - CmpW'(1));

	function automatic logic [AddrW-1:0] addr_of(input logic [RiW-1:0] r,
	                                             input logic [CiW-1:0] c);
		addr_of = AddrW'(AddrW'(r) * AddrW'(MAX_COLS) + AddrW'(c));
	endfunction

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (cmd.func == FUNC_READ && !rd_bad) begin
						state_d = ST_RD_WAIT;
					end else if (cmd.func == FUNC_NORM && row_count_q != '0) begin
						state_d = ST_SUM_RD;
					end
				end
			end
			ST_RD_WAIT:  state_d = ST_IDLE;
			ST_SUM_RD:   state_d = ST_SUM_ACC;
			ST_SUM_ACC:  state_d = row_last ? ST_MEAN_DIV : ST_SUM_RD;
			ST_MEAN_DIV: if (div_done) state_d = ST_SQ_RD;
			ST_SQ_RD:    state_d = ST_SQ_D;
			ST_SQ_D:     state_d = ST_SQ_MUL;
			ST_SQ_MUL:   state_d = ST_SQ_ACC;
			ST_SQ_ACC:   state_d = row_last ? ST_VAR_DIV : ST_SQ_RD;
			ST_VAR_DIV:  if (div_done) state_d = ST_SQRT;
			ST_SQRT: begin
				if (sqrt_done) state_d = (sqrt_root == '0) ? ST_ZERO_WR : ST_N_RD;
			end
			ST_ZERO_WR:  if (row_last) state_d = ST_COL_NEXT;
			ST_N_RD:     state_d = ST_N_D;
			ST_N_D:      state_d = ST_N_DIV;
			ST_N_DIV:    if (div_done) state_d = ST_N_WR;
			ST_N_WR:     state_d = row_last ? ST_COL_NEXT : ST_N_RD;
			ST_COL_NEXT: state_d = col_last ? ST_DONE : ST_SUM_RD;
			ST_DONE:     state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		mem_we = 1'b0;
		waddr  = addr_of(r_q, c_q);
		wdata  = '0;
		raddr  = addr_of(r_q, c_q);
		unique case (state_q)
			ST_IDLE: begin
				raddr = addr_of(RiW'(cmd.row_index), CiW'(cmd.col_index));
				waddr = addr_of(RiW'(row_count_q), col_ptr_q);
				wdata = cmd.sample_value;
				mem_we = accept && cmd.func == FUNC_STORE &&
				         CmpW'(row_count_q) < CmpW'(MAX_ROWS);
			end
			ST_ZERO_WR: mem_we = 1'b1;
			ST_N_WR: begin
				mem_we = 1'b1;
				wdata  = zval;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	assign sum_mag  = sum_q[SumW-1] ? SumW'(-sum_q) : SumW'(sum_q);
	assign mean_mag = div_quo[31:0] + 32'((sum_q[SumW-1] && div_rem != '0) ? 1 : 0);
	assign dval     = {rdata_q[31], rdata_q} - {mean_q[31], mean_q};
	assign prod     = mag_q * mag_q;

	always_comb begin
		div_dividend = DivW'(sum_mag);
		div_divisor  = 32'(row_count_q);
		if (state_q == ST_VAR_DIV) begin
			div_dividend = DivW'(sumsq_q);
		end else if (state_q == ST_N_DIV) begin
			div_dividend = DivW'({mag_q, {FRAC_BITS{1'b0}}});
			div_divisor  = dev_q;
		end
	end

	always_comb begin
		if (dneg_q) begin
			if (div_quo > DivW'(33'h080000000)) zval = 32'h80000000;
			else zval = 32'(-div_quo[31:0]);
		end else begin
			if (div_quo > DivW'(33'h07FFFFFFF)) zval = 32'h7FFFFFFF;
			else zval = div_quo[31:0];
		end
	end

	czn_divider #(.DivW(DivW), .DsrW(32)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (unit_go_q && state_q != ST_SQRT),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quo),
		.remainder(div_rem)
	);

	czn_isqrt u_sqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (unit_go_q && state_q == ST_SQRT),
		.radicand(var_q),
		.done    (sqrt_done),
		.root    (sqrt_root)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			num_cols_q  <= 5'd1;
			row_count_q <= '0;
			col_ptr_q   <= '0;
			rsp_valid_q <= 1'b0;
			unit_go_q   <= 1'b0;
		end else begin
			state_q     <= state_d;
			rsp_valid_q <= 1'b0;
			unit_go_q   <= (state_d != state_q) &&
			               (state_d == ST_MEAN_DIV || state_d == ST_VAR_DIV ||
			                state_d == ST_N_DIV || state_d == ST_SQRT);
			if (cfg_we) begin
				num_cols_q  <= cfg_wdata;
				row_count_q <= '0;
				col_ptr_q   <= '0;
			end else if (accept) begin
				case (cmd.func)
					FUNC_STORE: begin
						if (mem_we) begin
							if (CmpW'(col_ptr_q) + CmpW'(1) >= CmpW'(ncols)) begin
								col_ptr_q   <= '0;
								row_count_q <= row_count_q + 1'b1;
							end else begin
								col_ptr_q <= col_ptr_q + 1'b1;
							end
						end
						rsp_valid_q <= 1'b1;
					end
					FUNC_CLEAR: begin
						row_count_q <= '0;
						col_ptr_q   <= '0;
						rsp_valid_q <= 1'b1;
					end
					FUNC_READ:  rsp_valid_q <= rd_bad;
					default:    rsp_valid_q <= (row_count_q == '0);
				endcase
			end
			if (state_q == ST_RD_WAIT || state_q == ST_DONE) rsp_valid_q <= 1'b1;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				res_q    <= '0;
				status_q <= STAT_OK;
				r_q      <= '0;
				c_q      <= '0;
				sum_q    <= '0;
				sumsq_q  <= '0;
				zdev_q   <= 1'b0;
				if (accept) begin
					case (cmd.func)
						FUNC_STORE: begin
							if (!mem_we) status_q <= STAT_FULL;
						end
						FUNC_READ: begin
							if (rd_bad) status_q <= STAT_RANGE;
						end
						FUNC_NORM: begin
							if (row_count_q == '0) status_q <= STAT_EMPTY;
						end
						default: ;
					endcase
				end
			end
			ST_RD_WAIT: res_q <= rdata_q;
			ST_SUM_ACC: begin
				sum_q <= sum_q + SumW'($signed(rdata_q));
				r_q   <= row_last ? '0 : r_q + 1'b1;
			end
			ST_MEAN_DIV: begin
				if (div_done) mean_q <= sum_q[SumW-1] ? -mean_mag : mean_mag;
			end
			ST_SQ_D, ST_N_D: begin
				dneg_q <= dval[32];
				mag_q  <= dval[32] ? 33'(-dval) : 33'(dval);
			end
			ST_SQ_MUL: sq_q <= prod[63:0];
			ST_SQ_ACC: begin
				sumsq_q <= sumsq_q + SsW'(sq_q);
				r_q     <= row_last ? '0 : r_q + 1'b1;
			end
			ST_VAR_DIV: begin
				if (div_done) var_q <= div_quo[RadW-1:0];
			end
			ST_SQRT: begin
				if (sqrt_done) begin
					dev_q <= sqrt_root;
					if (sqrt_root == '0) zdev_q <= 1'b1;
				end
			end
			ST_ZERO_WR, ST_N_WR: r_q <= row_last ? '0 : r_q + 1'b1;
			ST_COL_NEXT: begin
				c_q     <= c_q + 1'b1;
				sum_q   <= '0;
				sumsq_q <= '0;
			end
			ST_DONE: begin
				if (zdev_q) status_q <= STAT_ZERODEV;
			end
			default: ;
		endcase
	end

	assign rsp_valid        = rsp_valid_q;
	assign rsp.result_value = res_q;
	assign rsp.status       = status_q;
	assign rsp.rows_held    = 9'(row_count_q);

`ifndef SYNTHESIS
	a_rsp_idle: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !busy) else $error("response while busy");
	a_rows_max: assert property (@(posedge clk) disable iff (!arst_n)
		CmpW'(row_count_q) <= CmpW'(MAX_ROWS)) else $error("row count overflow");
	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		CmpW'(col_ptr_q) < CmpW'(ncols)) else $error("column pointer out of range");
	a_answer: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (busy || rsp_valid)) else $error("item dropped");
`endif

endmodule
`default_nettype wire
